FILE: rtl/ternary_negation_propagate_macros.svh
// Assertion macros shared by the RTL of the negation propagator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TERNARY_NEGATION_PROPAGATE_MACROS_SVH
`define TERNARY_NEGATION_PROPAGATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TNP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TNP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tnp_pkg.sv
// Package for the negation propagator: vector width, item types, status codes
// and the bit-position helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tnp_pkg;

  localparam int unsigned VEC_WIDTH = 32;
  localparam int unsigned POS_W     = $clog2(VEC_WIDTH);
  localparam int unsigned CNT_W     = $clog2(VEC_WIDTH + 1);

  typedef logic [VEC_WIDTH-1:0] vec_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cnt_t VEC_CNT = cnt_t'(VEC_WIDTH);

  typedef enum logic [1:0] {
    ST_NOCHANGE = 2'd0,
    ST_CHANGED  = 2'd1,
    ST_CONFLICT = 2'd2
  } status_e;

  typedef struct packed {
    vec_t x_known;
    vec_t x_bits;
    vec_t y_known;
    vec_t y_bits;
  } in_item_t;

  typedef struct packed {
    vec_t    x_known_out;
    vec_t    x_bits_out;
    vec_t    y_known_out;
    vec_t    y_bits_out;
    status_e status;
  } out_item_t;

  function automatic pos_t lowest_idx(vec_t v);
    pos_t r;
    r = '0;
    for (int i = VEC_WIDTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = pos_t'(i);
      end
    end
    return r;
  endfunction

  function automatic pos_t highest_idx(vec_t v);
    pos_t r;
    r = '0;
    for (int i = 0; i < VEC_WIDTH; i++) begin
      if (v[i]) begin
        r = pos_t'(i);
      end
    end
    return r;
  endfunction

  function automatic vec_t low_mask(cnt_t b);
    vec_t m;
    for (int i = 0; i < VEC_WIDTH; i++) begin
      m[i] = (cnt_t'(i) < b);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ternary_negation_propagate.sv
// Top level of the negation propagator: a four-stage pipeline that refines
// two partially known vectors related by y = -x. Depends on tnp_pkg and the macro header.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | in_valid_i, in_stall_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o, out_stall_i| out_item_o (out_item_t)
//
// One item enters every cycle while in_stall_o is low; each result passes through
// four register stages in order: operand encodes, feasible range, range bounds,
// and the per-bit refinement that loads the output register.
// Reset clears only the stage valid bits.
// A stall holds the output register and closes bubbles in the stages behind it.
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_negation_propagate_macros.svh"

module ternary_negation_propagate (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  tnp_pkg::in_item_t     in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output tnp_pkg::out_item_t    out_item_o
);
  import tnp_pkg::*;

  typedef struct packed {
    vec_t xf;
    vec_t xv;
    vec_t yf;
    vec_t yv;
    logic none;
    logic kn_any;
    pos_t kn_lo;
    logic df_any;
    pos_t df_lo;
    logic o2_any;
    pos_t o2_hi;
    logic z2_any;
    pos_t z2_hi;
  } s1_t;

  typedef struct packed {
    vec_t xf;
    vec_t xv;
    vec_t yf;
    vec_t yv;
    logic none;
    logic conf;
    vec_t feas;
    logic wf;
  } s2_t;

  typedef struct packed {
    vec_t xf;
    vec_t xv;
    vec_t yf;
    vec_t yv;
    logic none;
    logic conf;
    vec_t feas;
    logic wf;
    logic fne;
    pos_t l_pos;
    pos_t h_pos;
  } s3_t;

  logic      s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic      r1, r2, r3, r4;
  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  s3_t       s3_d, s3_q;
  out_item_t out_item_d, out_item_q;

  assign r4         = !out_valid_q || !out_stall_i;
  assign r3         = !s3_valid_q || r4;
  assign r2         = !s2_valid_q || r3;
  assign r1         = !s1_valid_q || r2;
  assign in_stall_o = !r1;

  always_comb begin
    vec_t xf, xv, yf, yv, both;
    xf = in_item_i.x_known;
    xv = in_item_i.x_bits & xf;
    yf = in_item_i.y_known;
    yv = in_item_i.y_bits & yf;
    both = xf & yf;
    s1_d.xf     = xf;
    s1_d.xv     = xv;
    s1_d.yf     = yf;
    s1_d.yv     = yv;
    s1_d.none   = ((xf | yf) == '0);
    s1_d.kn_any = ((xv | yv) != '0);
    s1_d.kn_lo  = lowest_idx(xv | yv);
    s1_d.df_any = ((both & (xv ^ yv)) != '0);
    s1_d.df_lo  = lowest_idx(both & (xv ^ yv));
    s1_d.o2_any = ((xv & yv) != '0);
    s1_d.o2_hi  = highest_idx(xv & yv);
    s1_d.z2_any = ((both & ~xv & ~yv) != '0);
    s1_d.z2_hi  = highest_idx(both & ~xv & ~yv);
  end

  always_comb begin
    cnt_t lo_c, hi_c;
    logic conf_c;
    vec_t hole, hi_msk;
    hi_c   = VEC_CNT;
    lo_c   = '0;
    conf_c = 1'b0;
    if (s1_q.kn_any) begin
      hi_c = cnt_t'(s1_q.kn_lo);
    end
    if (s1_q.df_any) begin
      if (s1_q.df_lo == '0) begin
        conf_c = 1'b1;
      end else if (cnt_t'(s1_q.df_lo) - cnt_t'(1) < hi_c) begin
        hi_c = cnt_t'(s1_q.df_lo) - cnt_t'(1);
      end
    end
    if (s1_q.o2_any) begin
      lo_c = cnt_t'(s1_q.o2_hi);
    end
    if (s1_q.z2_any && (cnt_t'(s1_q.z2_hi) + cnt_t'(1) > lo_c)) begin
      lo_c = cnt_t'(s1_q.z2_hi) + cnt_t'(1);
    end
    if (lo_c > hi_c) begin
      conf_c = 1'b1;
    end
    hole   = (s1_q.xf & ~s1_q.xv) | (s1_q.yf & ~s1_q.yv);
    hi_msk = (hi_c == VEC_CNT) ? '1 : low_mask(hi_c + cnt_t'(1));
    s2_d.xf   = s1_q.xf;
    s2_d.xv   = s1_q.xv;
    s2_d.yf   = s1_q.yf;
    s2_d.yv   = s1_q.yv;
    s2_d.none = s1_q.none;
    s2_d.conf = conf_c;
    s2_d.feas = ~hole & ~low_mask(lo_c) & hi_msk;
    s2_d.wf   = (hi_c == VEC_CNT);
  end

  always_comb begin
    s3_d.xf    = s2_q.xf;
    s3_d.xv    = s2_q.xv;
    s3_d.yf    = s2_q.yf;
    s3_d.yv    = s2_q.yv;
    s3_d.none  = s2_q.none;
    s3_d.feas  = s2_q.feas;
    s3_d.wf    = s2_q.wf;
    s3_d.fne   = (s2_q.feas != '0);
    s3_d.conf  = s2_q.conf || ((s2_q.feas == '0) && !s2_q.wf);
    s3_d.l_pos = lowest_idx(s2_q.feas);
    s3_d.h_pos = highest_idx(s2_q.feas);
  end

  always_comb begin
    vec_t xf, xv, yf, yv, unk, lbit, hbit, rng, bmask, gt, region, above;
    vec_t bx0, bx1, x0, x1, y0, y1, cf_vec, xset, yset, from_x, from_y;
    vec_t nxf, nxv, nyf, nyv;
    logic changed;
    xf   = s3_q.xf;
    xv   = s3_q.xv;
    yf   = s3_q.yf;
    yv   = s3_q.yv;
    lbit = vec_t'(1) << s3_q.l_pos;
    hbit = vec_t'(1) << s3_q.h_pos;
    rng  = s3_q.fne ? (~low_mask(cnt_t'(s3_q.l_pos)) &
                       low_mask(cnt_t'(s3_q.h_pos) + cnt_t'(1))) : '0;
    bmask  = rng & ~lbit;
    gt     = s3_q.wf ? rng : (rng & ~hbit);
    region = s3_q.fne ? low_mask(cnt_t'(s3_q.l_pos)) : '1;
    above  = (s3_q.fne && !s3_q.wf) ? ~low_mask(cnt_t'(s3_q.h_pos) + cnt_t'(1)) : '0;
    unk    = ~xf & ~yf;
    bx0    = (xf & ~xv) | (~xf & yf & yv) | unk;
    bx1    = (xf & xv) | (~xf & yf & ~yv) | unk;
    x0     = (gt | (bmask & bx0)) & ~(xf & xv);
    x1     = (s3_q.feas | (bmask & bx1)) & ~(xf & ~xv);
    y0     = (gt | (bmask & bx1)) & ~(yf & yv);
    y1     = (s3_q.feas | (bmask & bx0)) & ~(yf & ~yv);
    cf_vec = rng & ((~x0 & ~x1) | (~y0 & ~y1));
    xset   = rng & ~xf & (x0 ^ x1);
    yset   = rng & ~yf & (y0 ^ y1);
    from_x = above & xf & ~yf;
    from_y = above & yf & ~xf;
    nxf    = xf | region | xset | from_y;
    nxv    = (xv & ~region) | (xset & x1) | (from_y & ~yv);
    nyf    = yf | region | yset | from_x;
    nyv    = (yv & ~region) | (yset & y1) | (from_x & ~xv);
    changed = ((region & ~(xf & yf)) != '0) || (xset != '0) || (yset != '0) ||
              ((from_x | from_y) != '0);
    if (s3_q.none) begin
      out_item_d = '{x_known_out: xf, x_bits_out: xv, y_known_out: yf, y_bits_out: yv,
                     status: ST_NOCHANGE};
    end else if (s3_q.conf || (cf_vec != '0)) begin
      out_item_d = '{x_known_out: xf, x_bits_out: xv, y_known_out: yf, y_bits_out: yv,
                     status: ST_CONFLICT};
    end else begin
      out_item_d = '{x_known_out: nxf, x_bits_out: nxv, y_known_out: nyf, y_bits_out: nyv,
                     status: changed ? ST_CHANGED : ST_NOCHANGE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (r1) s1_valid_q <= in_valid_i;
      if (r2) s2_valid_q <= s1_valid_q;
      if (r3) s3_valid_q <= s2_valid_q;
      if (r4) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) s1_q <= s1_d;
    if (r2 && s1_valid_q) s2_q <= s2_d;
    if (r3 && s2_valid_q) s3_q <= s3_d;
    if (r4 && s3_valid_q) out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `TNP_ASSERT_IMP(a_stall_only_when_full, in_stall_o,
    s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q,
    "Input stalled while a pipeline stage is empty.")
  `TNP_ASSERT_NXT(a_s3_holds, s3_valid_q && out_valid_q && out_stall_i,
    s3_valid_q && $stable(s3_q), "Stage three item changed under a stall.")
  `TNP_ASSERT_IMP(a_known_grows, s3_valid_q && out_item_d.status != ST_CONFLICT,
    ((out_item_d.x_known_out & s3_q.xf) == s3_q.xf) &&
    ((out_item_d.y_known_out & s3_q.yf) == s3_q.yf),
    "Refinement dropped a known bit.")
  `TNP_ASSERT_IMP(a_nochange_exact, s3_valid_q && out_item_d.status == ST_NOCHANGE,
    (out_item_d.x_known_out == s3_q.xf) && (out_item_d.y_known_out == s3_q.yf),
    "Status reports no change but a known mask changed.")

endmodule

`default_nettype wire
